FILE: rtl/psrl_pkg.sv
// Shared types and constants for the prime rank lookup block.
`timescale 1ns / 1ps

package psrl_pkg;

  localparam int unsigned QUERY_W = 16;
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned RANK_W  = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;
  localparam logic [RANK_W-1:0]  RANK_MAX    = {RANK_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_TEST,
    S_CHK,
    S_MARK,
    S_RANK,
    S_LOOK,
    S_RES
  } psrl_state_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic in_range;
  } psrl_stat_t;

endpackage

FILE: rtl/psrl_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module psrl_ram #(
  parameter int unsigned W     = 1,
  parameter int unsigned AW    = 2,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/psrl_ctrl.sv
// Sequencer for sieve build, rank pass and query lookup, around one shared adder.
`timescale 1ns / 1ps

module psrl_ctrl
  import psrl_pkg::*;
#(
  parameter int unsigned AW = 16,
  parameter int unsigned LW = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [QUERY_W-1:0] query,
  input  logic [LW-1:0]      lim,
  input  logic               built_clr,
  output psrl_stat_t         stat,
  // composite map
  output logic               cmp_we,
  output logic [AW-1:0]      cmp_waddr,
  output logic               cmp_wdata,
  output logic [AW-1:0]      cmp_raddr,
  input  logic               cmp_rdata,
  // rank store
  output logic               rnk_we,
  output logic [AW-1:0]      rnk_waddr,
  output logic [RANK_W-1:0]  rnk_wdata,
  output logic [AW-1:0]      rnk_raddr
);

  localparam int unsigned CW = LW + 1;

  psrl_state_t       state_r, state_nxt;
  logic              built_r, built_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic [LW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     sq_r, sq_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     paddr_r, paddr_nxt;
  logic [AW-1:0]     q_r, q_nxt;
  logic              inr_r, inr_nxt;

  // shared adder and comparator
  logic [CW-1:0] add_a, add_b, add_sum;
  logic          add_cin;
  logic [CW-1:0] lt_a;
  logic          lt;

  logic [LW-1:0]     qx;
  logic [RANK_W-1:0] rank_inc;

  assign add_sum  = add_a + add_b + CW'(add_cin);
  assign lt       = lt_a < CW'(lim);
  assign qx       = LW'(query);
  assign rank_inc = (rank_r == RANK_MAX) ? rank_r : rank_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      built_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    i_r     <= i_nxt;
    sq_r    <= sq_nxt;
    j_r     <= j_nxt;
    rank_r  <= rank_nxt;
    paddr_r <= paddr_nxt;
    q_r     <= q_nxt;
    inr_r   <= inr_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    sq_nxt    = sq_r;
    j_nxt     = j_r;
    rank_nxt  = rank_r;
    pend_nxt  = 1'b0;
    paddr_nxt = paddr_r;
    q_nxt     = q_r;
    inr_nxt   = inr_r;

    add_a   = CW'(cnt_r);
    add_b   = '0;
    add_cin = 1'b1;
    lt_a    = CW'(cnt_r);

    cmp_we    = 1'b0;
    cmp_waddr = cnt_r[AW-1:0];
    cmp_wdata = 1'b0;
    cmp_raddr = cnt_r[AW-1:0];
    rnk_we    = 1'b0;
    rnk_waddr = paddr_r;
    rnk_wdata = '0;
    rnk_raddr = q_r;

    if (built_clr) begin
      built_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // lookup read runs speculatively on the incoming value
        rnk_raddr = qx[AW-1:0];
        if (start) begin
          q_nxt   = qx[AW-1:0];
          inr_nxt = qx < lim;
          if (built_r) begin
            state_nxt = S_RES;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        if (lt) begin
          cmp_we    = 1'b1;
          cmp_wdata = cnt_r < LW'(2);
          cnt_nxt   = add_sum[LW-1:0];
        end else begin
          i_nxt     = LW'(2);
          sq_nxt    = CW'(4);
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        lt_a      = sq_r;
        cmp_raddr = i_r[AW-1:0];
        if (lt) begin
          state_nxt = S_CHK;
        end else begin
          cnt_nxt   = '0;
          rank_nxt  = '0;
          state_nxt = S_RANK;
        end
      end
      S_CHK: begin
        if (cmp_rdata) begin
          // (i+1)^2 = i^2 + 2i + 1
          add_a     = sq_r;
          add_b     = {i_r, 1'b0};
          add_cin   = 1'b1;
          sq_nxt    = add_sum;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_TEST;
        end else begin
          add_a     = CW'(i_r);
          add_b     = CW'(i_r);
          add_cin   = 1'b0;
          j_nxt     = add_sum;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        lt_a = j_r;
        if (lt) begin
          cmp_we    = 1'b1;
          cmp_waddr = j_r[AW-1:0];
          cmp_wdata = 1'b1;
          add_a     = j_r;
          add_b     = CW'(i_r);
          add_cin   = 1'b0;
          j_nxt     = add_sum;
        end else begin
          add_a     = sq_r;
          add_b     = {i_r, 1'b0};
          add_cin   = 1'b1;
          sq_nxt    = add_sum;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_RANK: begin
        // read composite[cnt] now, write rank in the next cycle
        if (lt) begin
          pend_nxt  = 1'b1;
          paddr_nxt = cnt_r[AW-1:0];
          cnt_nxt   = add_sum[LW-1:0];
        end else if (!pend_r) begin
          built_nxt = 1'b1;
          state_nxt = S_LOOK;
        end
        if (pend_r) begin
          rnk_we = 1'b1;
          if (!cmp_rdata) begin
            rnk_wdata = rank_inc;
            rank_nxt  = rank_inc;
          end
        end
      end
      S_LOOK: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign stat.busy      = state_r != S_IDLE;
  assign stat.res_valid = state_r == S_RES;
  assign stat.in_range  = inr_r;

endmodule

FILE: rtl/prime_sieve_rank_lookup.sv
// Top level: prime rank lookup table built by a sieve of Eratosthenes.
`timescale 1ns / 1ps
// Query: with the table built, the result strobes in the cycle after start is taken;
//   one query at a time (one registered read of the rank RAM, then the result cycle).
// First query after reset or a limit write also builds the table for effective limit L: clear the
//   composite map, mark multiples of each prime p with p*p < L, then a rank pass over all L values.
// Reset clears the sequencer, the built flag and sets the limit to 65536; RAMs are not cleared.
// Results cannot be stalled; out_valid is a one-cycle strobe.

module prime_sieve_rank_lookup
  import psrl_pkg::*;
#(
  parameter int unsigned MAX_VALUES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  // query channel
  input  logic               start,
  output logic               busy,
  input  logic [QUERY_W-1:0] in_query_value,
  // result channel
  output logic               out_valid,
  output logic [RANK_W-1:0]  out_prime_rank,
  output logic               out_in_range,
  // limit register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_value_limit
);

  localparam int unsigned AW = $clog2(MAX_VALUES);
  // limit compare width: holds the 17-bit register and MAX_VALUES itself
  localparam int unsigned LW = (AW + 1 > LIMIT_W) ? AW + 1 : LIMIT_W;

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [LW-1:0]      limit_x, lim;
  logic               cfg_xfer;
  psrl_stat_t         stat;

  logic              cmp_we, cmp_wdata, cmp_rdata;
  logic [AW-1:0]     cmp_waddr, cmp_raddr;
  logic              rnk_we;
  logic [AW-1:0]     rnk_waddr, rnk_raddr;
  logic [RANK_W-1:0] rnk_wdata, rnk_rdata;

  // limit writes only land while idle and no query is being taken;
  // a transfer also drops the built flag
  assign cfg_ready = !stat.busy && !start;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign limit_nxt = cfg_xfer ? cfg_value_limit : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // effective limit saturates at the table depth
  assign limit_x = LW'(limit_r);
  assign lim     = (limit_x > LW'(MAX_VALUES)) ? LW'(MAX_VALUES) : limit_x;

  psrl_ctrl #(
    .AW (AW),
    .LW (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start && !stat.busy),
    .query     (in_query_value),
    .lim       (lim),
    .built_clr (cfg_xfer),
    .stat      (stat),
    .cmp_we    (cmp_we),
    .cmp_waddr (cmp_waddr),
    .cmp_wdata (cmp_wdata),
    .cmp_raddr (cmp_raddr),
    .cmp_rdata (cmp_rdata),
    .rnk_we    (rnk_we),
    .rnk_waddr (rnk_waddr),
    .rnk_wdata (rnk_wdata),
    .rnk_raddr (rnk_raddr)
  );

  // composite map: one bit per value
  psrl_ram #(
    .W     (1),
    .AW    (AW),
    .DEPTH (MAX_VALUES)
  ) u_cmp_ram (
    .clk   (clk),
    .we    (cmp_we),
    .waddr (cmp_waddr),
    .wdata (cmp_wdata),
    .raddr (cmp_raddr),
    .rdata (cmp_rdata)
  );

  // rank store: 1-based prime index, 0 for non-primes
  psrl_ram #(
    .W     (RANK_W),
    .AW    (AW),
    .DEPTH (MAX_VALUES)
  ) u_rnk_ram (
    .clk   (clk),
    .we    (rnk_we),
    .waddr (rnk_waddr),
    .wdata (rnk_wdata),
    .raddr (rnk_raddr),
    .rdata (rnk_rdata)
  );

  assign busy           = stat.busy;
  assign out_valid      = stat.res_valid;
  assign out_in_range   = stat.in_range;
  // out-of-range queries read a don't-care entry; mask it
  assign out_prime_rank = stat.in_range ? rnk_rdata : '0;

endmodule
